>>> hdl/half_sphere_exposure_counter_top_defines.svh
// Assertion macros shared by the half-sphere exposure counter.
`ifndef HALF_SPHERE_EXPOSURE_COUNTER_TOP_DEFINES_SVH
`define HALF_SPHERE_EXPOSURE_COUNTER_TOP_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define HSE_ASSERT_IMPL(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define HSE_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> hdl/hse_pkg.sv
// Package with types and constants of the half-sphere exposure counter.
`default_nettype none
package hse_pkg;
    localparam int MaxResidues = 1024;
    localparam int CoordBits   = 20;
    localparam int AddrBits    = $clog2(MaxResidues);
    localparam int TotalBits   = AddrBits + 1;
    localparam int CountBits   = 10;
    localparam int CutoffBits  = 42;
    localparam int CfgIdxBits  = 1;
    localparam int DiffBits    = CoordBits + 1;
    localparam int SqBits      = 2 * DiffBits;
    localparam int DistBits    = SqBits + 2;
    localparam int ProdBits    = 2 * DiffBits;
    localparam int DotBits     = ProdBits + 2;
    localparam logic [CountBits-1:0] CountMax = '1;
    localparam logic [CutoffBits-1:0] CutoffReset = 42'd11075584;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [CfgIdxBits-1:0] REG_CUTOFF = 1'b0;
    localparam logic [CfgIdxBits-1:0] REG_ALPHA  = 1'b1;

    typedef struct packed {
        logic [1:0]                  opcode;
        logic [9:0]                  read_index;
        logic signed [CoordBits-1:0] ca_x;
        logic signed [CoordBits-1:0] ca_y;
        logic signed [CoordBits-1:0] ca_z;
        logic signed [CoordBits-1:0] cb_x;
        logic signed [CoordBits-1:0] cb_y;
        logic signed [CoordBits-1:0] cb_z;
        logic                        has_side_chain;
        logic                        present;
    } t_in_item;

    typedef struct packed {
        logic [9:0]           residue_index;
        logic [CountBits-1:0] contact_count;
        logic [CountBits-1:0] up_count;
        logic [CountBits-1:0] down_count;
        logic                 reported;
    } t_out_item;

    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic signed [CoordBits-1:0] z;
    } t_centre;

    typedef struct packed {
        logic signed [DiffBits-1:0] x;
        logic signed [DiffBits-1:0] y;
        logic signed [DiffBits-1:0] z;
    } t_dir;

    typedef struct packed {
        logic [CountBits-1:0] contact;
        logic [CountBits-1:0] up;
        logic [CountBits-1:0] down;
    } t_counts;

    // Geometry entry: centre, direction and present bit.
    typedef struct packed {
        t_centre c;
        t_dir    d;
        logic    present;
    } t_geom;

    // Outcome of one pair comparison.
    typedef struct packed {
        logic hit;
        logic old_up;
        logic new_up;
    } t_pair;

    function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] c);
        bump = (c == CountMax) ? c : c + 1'b1;
    endfunction
endpackage
`default_nettype wire

>>> hdl/half_sphere_exposure_counter_top.sv
// Top level of the half-sphere exposure counter: sequencer, stores and pair unit.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | i_in_valid/o_in_stall | i_in_item  (hse_pkg::t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (hse_pkg::t_out_item)
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// During an add over N > 0 stored residues, the old residues stream once
// through the geometry and count RAM read ports and the three-stage pair unit.
// The first add into an empty store skips the scan and goes straight to the drain.
// A clear or an ignored opcode keeps the block idle; a read holds in S_OUT while stalled.
// Reset is synchronous and active low; the stores themselves are never cleared.
// A new transaction is taken only once the previous one has finished.
`default_nettype none
`include "half_sphere_exposure_counter_top_defines.svh"
module half_sphere_exposure_counter_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire hse_pkg::t_in_item           i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output hse_pkg::t_out_item               o_out_item,
    input  wire logic                        i_cfg_we,
    input  wire logic [hse_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  wire logic [hse_pkg::CutoffBits-1:0] i_cfg_data
);
    localparam int AB = hse_pkg::AddrBits;
    localparam int TB = hse_pkg::TotalBits;
    localparam int GB = $bits(hse_pkg::t_geom);
    localparam int CB = $bits(hse_pkg::t_counts);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_READ  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [TB-1:0]          r_total;
    logic [hse_pkg::CutoffBits-1:0] r_cutoff;
    logic                   r_alpha;
    logic [TB-1:0]          r_rd_cnt;
    logic [AB-1:0]          r_rd_addr;
    logic [AB-1:0]          r_p1, r_p2, r_p3, r_p4;
    logic                   r_pv1;
    hse_pkg::t_centre       r_nc;
    hse_pkg::t_dir          r_nd;
    hse_pkg::t_counts       r_ncnt;
    logic [9:0]             r_ridx;
    logic                   r_rok;

    logic                   w_accept;
    hse_pkg::t_opcode       w_op;
    logic                   w_gwe;
    logic [AB-1:0]          w_graddr;
    logic [GB-1:0]          w_grd;
    hse_pkg::t_geom         w_gold;
    logic                   w_cwe;
    logic [AB-1:0]          w_cwa;
    hse_pkg::t_counts       w_cwd;
    logic [CB-1:0]          w_crd;
    hse_pkg::t_counts       w_cold;
    logic [AB-1:0]          w_craddr;
    logic                   w_pv;
    hse_pkg::t_pair         w_pair;
    hse_pkg::t_centre       w_c;
    hse_pkg::t_dir          w_d;
    logic                   w_usecb;
    hse_pkg::t_geom         w_gnew;
    logic [3:0]             r_cv;
    hse_pkg::t_counts       r_cold;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_op       = hse_pkg::t_opcode'(i_in_item.opcode);
    assign w_usecb    = !r_alpha && i_in_item.has_side_chain;

    always_comb begin
        w_c.x = w_usecb ? i_in_item.cb_x : i_in_item.ca_x;
        w_c.y = w_usecb ? i_in_item.cb_y : i_in_item.ca_y;
        w_c.z = w_usecb ? i_in_item.cb_z : i_in_item.ca_z;
        w_d.x = hse_pkg::DiffBits'(i_in_item.cb_x) - hse_pkg::DiffBits'(i_in_item.ca_x);
        w_d.y = hse_pkg::DiffBits'(i_in_item.cb_y) - hse_pkg::DiffBits'(i_in_item.ca_y);
        w_d.z = hse_pkg::DiffBits'(i_in_item.cb_z) - hse_pkg::DiffBits'(i_in_item.ca_z);
        w_gnew.c = w_c;
        w_gnew.d = w_d;
        w_gnew.present = i_in_item.present;
    end

    assign w_gwe = w_accept && (w_op == hse_pkg::OP_ADD) && (r_total != TB'(hse_pkg::MaxResidues));

    // While idle both stores are addressed straight from the offered read index, so a read
    // has its entry in the cycle after it is accepted.
    assign w_graddr = (r_state == S_IDLE) ? i_in_item.read_index[AB-1:0] : r_rd_addr;

    hse_ram #(.Width(GB), .Depth(hse_pkg::MaxResidues)) u_geom (
        .i_clk  (i_clk),
        .i_we   (w_gwe),
        .i_waddr(r_total[AB-1:0]),
        .i_wdata(w_gnew),
        .i_raddr(w_graddr),
        .o_rdata(w_grd)
    );
    assign w_gold = hse_pkg::t_geom'(w_grd);

    // Count read at r_p2 goes via the RAM register and r_cold to its write-back at r_p4.
    assign w_craddr = (r_state == S_IDLE) ? i_in_item.read_index[AB-1:0] : r_p2;

    hse_ram #(.Width(CB), .Depth(hse_pkg::MaxResidues)) u_cnt (
        .i_clk  (i_clk),
        .i_we   (w_cwe),
        .i_waddr(w_cwa),
        .i_wdata(w_cwd),
        .i_raddr(w_craddr),
        .o_rdata(w_crd)
    );
    assign w_cold = hse_pkg::t_counts'(w_crd);

    hse_pair u_pair (
        .i_clk      (i_clk),
        .i_valid    (r_pv1),
        .i_new_c    (r_nc),
        .i_new_d    (r_nd),
        .i_old      (w_gold),
        .i_cutoff_sq(r_cutoff),
        .o_valid    (w_pv),
        .o_pair     (w_pair)
    );

    // Old-entry update at pair output; the new entry is written when the drain ends.
    always_comb begin
        w_cwe = 1'b0;
        w_cwa = r_p4;
        w_cwd = r_cold;
        if (w_pv && w_pair.hit) begin
            w_cwe = 1'b1;
            w_cwd.contact = hse_pkg::bump(r_cold.contact);
            if (w_pair.old_up) begin
                w_cwd.up = hse_pkg::bump(r_cold.up);
            end else begin
                w_cwd.down = hse_pkg::bump(r_cold.down);
            end
        end
        if (r_state == S_DRAIN && !w_pv && r_cv == 4'd0) begin
            w_cwe = 1'b1;
            w_cwa = r_total[AB-1:0];
            w_cwd = r_ncnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_gwe) begin
                        n_state = (r_total == '0) ? S_DRAIN : S_SCAN;
                    end else if (w_op == hse_pkg::OP_READ) begin
                        n_state = S_READ;
                    end
                end
            end
            S_SCAN:  if (r_rd_cnt == r_total) n_state = S_DRAIN;
            S_DRAIN: if (!w_pv && r_cv == 4'd0) n_state = S_IDLE;
            S_READ:  n_state = S_OUT;
            S_OUT:   if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_cutoff <= hse_pkg::CutoffReset;
            r_alpha  <= 1'b0;
            r_pv1    <= 1'b0;
            r_cv     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == hse_pkg::REG_CUTOFF) r_cutoff <= i_cfg_data;
                if (i_cfg_index == hse_pkg::REG_ALPHA)  r_alpha  <= i_cfg_data[0];
            end
            if (w_accept && w_op == hse_pkg::OP_CLEAR) r_total <= '0;
            if (r_state == S_DRAIN && n_state == S_IDLE) r_total <= r_total + 1'b1;
            r_pv1 <= (r_state == S_SCAN) && (r_rd_cnt != r_total);
            r_cv  <= {r_cv[2:0], (r_state == S_SCAN) && (r_rd_cnt != r_total)};
            if (r_state == S_READ) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_nc     <= w_c;
            r_nd     <= w_d;
            r_ncnt   <= '0;
            r_rd_cnt <= '0;
            r_rd_addr <= (w_op == hse_pkg::OP_READ) ? i_in_item.read_index[AB-1:0] : '0;
            r_ridx   <= i_in_item.read_index;
            r_rok    <= TB'(i_in_item.read_index) < r_total;
        end else if (r_state == S_SCAN && r_rd_cnt != r_total) begin
            r_rd_cnt  <= r_rd_cnt + 1'b1;
            r_rd_addr <= r_rd_cnt[AB-1:0] + 1'b1;
        end
        r_p1 <= r_rd_cnt[AB-1:0];
        r_p2 <= r_p1;
        r_p3 <= r_p2;
        r_p4 <= r_p3;
        r_cold <= w_cold;
        if (w_pv && w_pair.hit) begin
            r_ncnt.contact <= hse_pkg::bump(r_ncnt.contact);
            if (w_pair.new_up) r_ncnt.up <= hse_pkg::bump(r_ncnt.up);
            else r_ncnt.down <= hse_pkg::bump(r_ncnt.down);
        end
        if (r_state == S_READ) begin
            o_out_item.residue_index <= r_ridx;
            o_out_item.reported      <= r_rok && w_gold.present;
            o_out_item.contact_count <= (r_rok && w_gold.present) ? w_cold.contact : '0;
            o_out_item.up_count      <= (r_rok && w_gold.present) ? w_cold.up : '0;
            o_out_item.down_count    <= (r_rok && w_gold.present) ? w_cold.down : '0;
        end
    end

    `HSE_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !w_accept, "accept while busy")
    `HSE_ASSERT_IMPL(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= TB'(hse_pkg::MaxResidues), "total overflow")
    `HSE_ASSERT_NEXT(a_read_out, i_clk, i_rst_n, r_state == S_READ, o_out_valid, "read without result")
endmodule
`default_nettype wire

>>> hdl/hse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module hse_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/hse_pair.sv
// Pipelined pair unit: distance against cutoff and the two dot-product signs.
`default_nettype none
module hse_pair (
    input  wire logic                          i_clk,
    input  wire logic                          i_valid,
    input  wire hse_pkg::t_centre              i_new_c,
    input  wire hse_pkg::t_dir                 i_new_d,
    input  wire hse_pkg::t_geom                i_old,
    input  wire logic [hse_pkg::CutoffBits-1:0] i_cutoff_sq,
    output logic                               o_valid,
    output hse_pkg::t_pair                     o_pair
);
    localparam int DB = hse_pkg::DiffBits;
    localparam int PB = hse_pkg::ProdBits;

    // Stage 1: centre differences.
    logic                 r_v1;
    logic signed [DB-1:0] r_vx, r_vy, r_vz;
    hse_pkg::t_dir        r_od, r_nd;
    // Stage 2: products.
    logic                 r_v2;
    logic signed [PB-1:0] r_sx, r_sy, r_sz;
    logic signed [PB-1:0] r_ox, r_oy, r_oz;
    logic signed [PB-1:0] r_nx, r_ny, r_nz;
    logic [hse_pkg::DistBits-1:0]       n_dist;
    logic signed [hse_pkg::DotBits-1:0] n_doto, n_dotn;

    always_ff @(posedge i_clk) begin
        r_v1 <= i_valid;
        r_vx <= DB'(i_new_c.x) - DB'(i_old.c.x);
        r_vy <= DB'(i_new_c.y) - DB'(i_old.c.y);
        r_vz <= DB'(i_new_c.z) - DB'(i_old.c.z);
        r_od <= i_old.d;
        r_nd <= i_new_d;
        r_v2 <= r_v1;
        r_sx <= PB'(r_vx) * PB'(r_vx);
        r_sy <= PB'(r_vy) * PB'(r_vy);
        r_sz <= PB'(r_vz) * PB'(r_vz);
        r_ox <= PB'(r_vx) * PB'(r_od.x);
        r_oy <= PB'(r_vy) * PB'(r_od.y);
        r_oz <= PB'(r_vz) * PB'(r_od.z);
        r_nx <= PB'(r_vx) * PB'(r_nd.x);
        r_ny <= PB'(r_vy) * PB'(r_nd.y);
        r_nz <= PB'(r_vz) * PB'(r_nd.z);
        o_valid <= r_v2;
        o_pair.hit    <= n_dist <= hse_pkg::DistBits'(i_cutoff_sq);
        o_pair.old_up <= n_doto > 0;
        o_pair.new_up <= n_dotn < 0;
    end

    // Squares are non-negative, so their sum is taken unsigned.
    always_comb begin
        n_dist = hse_pkg::DistBits'(unsigned'(r_sx)) + hse_pkg::DistBits'(unsigned'(r_sy))
               + hse_pkg::DistBits'(unsigned'(r_sz));
        n_doto = hse_pkg::DotBits'(r_ox) + hse_pkg::DotBits'(r_oy) + hse_pkg::DotBits'(r_oz);
        n_dotn = hse_pkg::DotBits'(r_nx) + hse_pkg::DotBits'(r_ny) + hse_pkg::DotBits'(r_nz);
    end
endmodule
`default_nettype wire

>>> tb/hse_checker.sv
// Checker for the half-sphere exposure counter: watches the channels, predicts and compares.
`timescale 1ns / 1ps
module hse_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire hse_pkg::t_in_item              i_in_item,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire hse_pkg::t_out_item             i_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [hse_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  wire logic [hse_pkg::CutoffBits-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_reads_checked
);
    // Own copy of the block's configuration and residue store.
    logic [hse_pkg::CutoffBits-1:0] cutoff_sq;
    logic                           alpha_mode;
    int                             residue_total;
    longint                         centre [hse_pkg::MaxResidues][3];
    longint                         direction [hse_pkg::MaxResidues][3];
    int                             contacts [hse_pkg::MaxResidues];
    int                             ups [hse_pkg::MaxResidues];
    int                             downs [hse_pkg::MaxResidues];
    bit                             present_flag [hse_pkg::MaxResidues];
    hse_pkg::t_out_item             expected_counts [$];

    function automatic int sat_inc(int c);
        return (c < int'(hse_pkg::CountMax)) ? c + 1 : c;
    endfunction

    function automatic void add_residue(hse_pkg::t_in_item it);
        longint ca [3];
        longint cb [3];
        longint v [3];
        longint dist_sq;
        longint dot_old;
        longint dot_new;
        bit     use_cb;
        int     n;
        if (residue_total >= hse_pkg::MaxResidues) return;
        n = residue_total;
        ca[0] = longint'(it.ca_x); ca[1] = longint'(it.ca_y); ca[2] = longint'(it.ca_z);
        cb[0] = longint'(it.cb_x); cb[1] = longint'(it.cb_y); cb[2] = longint'(it.cb_z);
        use_cb = !alpha_mode && it.has_side_chain;
        for (int k = 0; k < 3; k++) begin
            centre[n][k]    = use_cb ? cb[k] : ca[k];
            direction[n][k] = cb[k] - ca[k];
        end
        contacts[n] = 0;
        ups[n] = 0;
        downs[n] = 0;
        present_flag[n] = it.present;
        for (int i = 0; i < n; i++) begin
            dist_sq = 0;
            dot_old = 0;
            dot_new = 0;
            for (int k = 0; k < 3; k++) begin
                v[k] = centre[n][k] - centre[i][k];
                dist_sq += v[k] * v[k];
            end
            if (dist_sq <= longint'(cutoff_sq)) begin
                for (int k = 0; k < 3; k++) begin
                    dot_old += v[k] * direction[i][k];
                    dot_new -= v[k] * direction[n][k];
                end
                contacts[i] = sat_inc(contacts[i]);
                contacts[n] = sat_inc(contacts[n]);
                // A zero dot product falls on the down side.
                if (dot_old > 0) ups[i] = sat_inc(ups[i]);
                else downs[i] = sat_inc(downs[i]);
                if (dot_new > 0) ups[n] = sat_inc(ups[n]);
                else downs[n] = sat_inc(downs[n]);
            end
        end
        residue_total++;
    endfunction

    function automatic hse_pkg::t_out_item read_counts(logic [9:0] idx);
        hse_pkg::t_out_item r;
        r = '0;
        r.residue_index = idx;
        if (int'(idx) < residue_total && present_flag[idx]) begin
            r.reported      = 1'b1;
            r.contact_count = hse_pkg::CountBits'(contacts[idx]);
            r.up_count      = hse_pkg::CountBits'(ups[idx]);
            r.down_count    = hse_pkg::CountBits'(downs[idx]);
        end
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_reads_checked = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        hse_pkg::t_out_item w;
        if (!i_rst_n) begin
            cutoff_sq     = hse_pkg::CutoffReset;
            alpha_mode    = 1'b0;
            residue_total = 0;
            expected_counts.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == hse_pkg::REG_CUTOFF) cutoff_sq = i_cfg_data;
                else if (i_cfg_index == hse_pkg::REG_ALPHA) alpha_mode = i_cfg_data[0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    report("unexpected transaction, index", i_out_item.residue_index, 0);
                end else begin
                    w = expected_counts.pop_front();
                    o_reads_checked++;
                    if (i_out_item.residue_index !== w.residue_index)
                        report("residue_index", i_out_item.residue_index, w.residue_index);
                    if (i_out_item.contact_count !== w.contact_count)
                        report("contact_count", i_out_item.contact_count, w.contact_count);
                    if (i_out_item.up_count !== w.up_count)
                        report("up_count", i_out_item.up_count, w.up_count);
                    if (i_out_item.down_count !== w.down_count)
                        report("down_count", i_out_item.down_count, w.down_count);
                    if (i_out_item.reported !== w.reported)
                        report("reported", i_out_item.reported, w.reported);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (hse_pkg::t_opcode'(i_in_item.opcode))
                    hse_pkg::OP_CLEAR: residue_total = 0;
                    hse_pkg::OP_ADD:   add_residue(i_in_item);
                    hse_pkg::OP_READ:
                        expected_counts.push_back(read_counts(i_in_item.read_index));
                    default: ;
                endcase
            end
        end
        o_pending = expected_counts.size();
    end
endmodule

>>> tb/testbench.sv
// Top of the half-sphere exposure counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    localparam int InBits = $bits(hse_pkg::t_in_item);
    localparam int CoordBits = hse_pkg::CoordBits;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_valid;
    logic                           in_stall;
    hse_pkg::t_in_item              in_item;
    logic                           out_valid;
    logic                           out_stall;
    hse_pkg::t_out_item             out_item;
    logic                           cfg_we;
    logic [hse_pkg::CfgIdxBits-1:0] cfg_index;
    logic [hse_pkg::CutoffBits-1:0] cfg_data;
    int                             fail_count;
    int                             pending;
    int                             reads_checked;

    // Stimulus state; calm and squeeze_req are shared with the receiver process.
    bit     calm;
    bit     squeeze_req;
    int     items_sent;
    int     stored_guess;
    longint cluster [3];
    int     spread;
    bit     full_range;

    half_sphere_exposure_counter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hse_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_reads_checked (reads_checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus one long hold-off once asked for.
    initial begin
        int  hold_left;
        bit  squeezed;
        hold_left = 0;
        squeezed = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze_req && !squeezed) begin
                squeezed = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (calm || !i_rst_n) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 26);
            end
        end
    end

    task automatic send(hse_pkg::t_in_item it);
        if (!calm && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
        case (hse_pkg::t_opcode'(it.opcode))
            hse_pkg::OP_CLEAR: stored_guess = 0;
            hse_pkg::OP_ADD:   if (stored_guess < hse_pkg::MaxResidues) stored_guess++;
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [hse_pkg::CfgIdxBits-1:0] idx,
                             logic [hse_pkg::CutoffBits-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every read has come back and a full-store add has surely finished.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (hse_pkg::MaxResidues + 40) @(posedge i_clk);
    endtask

    function automatic logic [CoordBits-1:0] near(longint base, int dev);
        return CoordBits'(base + $urandom_range(0, 2 * dev) - dev);
    endfunction

    function automatic hse_pkg::t_in_item random_item();
        return hse_pkg::t_in_item'(InBits'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    endfunction

    function automatic hse_pkg::t_in_item make_add();
        hse_pkg::t_in_item it;
        it = '0;
        it.opcode     = hse_pkg::OP_ADD;
        it.read_index = 10'($urandom);
        if (full_range) begin
            it.ca_x = CoordBits'($urandom);
            it.ca_y = CoordBits'($urandom);
            it.ca_z = CoordBits'($urandom);
        end else begin
            it.ca_x = near(cluster[0], spread);
            it.ca_y = near(cluster[1], spread);
            it.ca_z = near(cluster[2], spread);
        end
        // CB point near CA, in full range at times anywhere; sometimes exactly on it.
        if ($urandom_range(9) == 0) begin
            it.cb_x = it.ca_x; it.cb_y = it.ca_y; it.cb_z = it.ca_z;
        end else if (full_range && $urandom_range(1)) begin
            it.cb_x = CoordBits'($urandom);
            it.cb_y = CoordBits'($urandom);
            it.cb_z = CoordBits'($urandom);
        end else begin
            it.cb_x = near(it.ca_x, 400);
            it.cb_y = near(it.ca_y, 400);
            it.cb_z = near(it.ca_z, 400);
        end
        it.has_side_chain = ($urandom_range(9) != 0);
        it.present        = ($urandom_range(9) != 0);
        return it;
    endfunction

    function automatic hse_pkg::t_in_item make_read(int idx);
        hse_pkg::t_in_item it;
        it = random_item();
        it.opcode     = hse_pkg::OP_READ;
        it.read_index = 10'(idx);
        return it;
    endfunction

    function automatic hse_pkg::t_in_item make_random();
        hse_pkg::t_in_item it;
        int                roll;
        roll = $urandom_range(99);
        if (roll < 2) begin
            it = random_item();
            it.opcode = hse_pkg::OP_CLEAR;
        end else if (roll < 5) begin
            it = random_item();
            it.opcode = hse_pkg::OP_NONE;
        end else if (roll < 55) begin
            it = make_add();
        end else if (roll < 90 && stored_guess > 0) begin
            it = make_read($urandom_range(0, stored_guess - 1));
        end else begin
            it = make_read($urandom_range(0, 1023));
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < 3; k++) cluster[k] = longint'($urandom_range(0, 1000000)) - 500000;
        for (int n = 0; n < count; n++) send(make_random());
    endtask

    initial begin
        hse_pkg::t_in_item it;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm = 0;
        squeeze_req = 0;
        items_sent = 0;
        stored_guess = 0;
        spread = 900;
        full_range = 0;
        cluster[0] = 0; cluster[1] = 0; cluster[2] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset configuration.
        send(make_read(0));
        send(make_read(1023));
        it = make_add();
        it.opcode = hse_pkg::OP_NONE;
        send(it);
        it = '0;
        it.opcode = hse_pkg::OP_ADD;
        it.ca_x = 20'sh7FFFF; it.ca_y = 20'sh80000; it.ca_z = 20'sh7FFFF;
        it.cb_x = 20'sh80000; it.cb_y = 20'sh7FFFF; it.cb_z = 20'sh80000;
        it.has_side_chain = 1; it.present = 1; it.read_index = 10'h3FF;
        send(it);
        // Two residues on one spot with no direction: a contact with zero dot products.
        it = '0;
        it.opcode = hse_pkg::OP_ADD; it.present = 1; it.has_side_chain = 1;
        send(it);
        send(it);
        it.cb_x = 20'sd300;
        it.present = 0;
        send(it);
        it.has_side_chain = 0; it.present = 1; it.ca_y = 20'sd500; it.cb_y = 20'sd500;
        send(it);
        for (int i = 0; i < 6; i++) send(make_read(i));
        it = '0;
        it.opcode = hse_pkg::OP_CLEAR;
        send(it);
        send(make_read(0));
        send(make_read(2));
        for (int i = 0; i < 3; i++) send(make_add());
        send(make_read(1));

        // Long hold-off on the results while reads arrive, then random and calm phases.
        squeeze_req <= 1'b1;
        for (int i = 0; i < 30; i++) send(make_read($urandom_range(0, 3)));
        random_phase(40);
        calm = 1;
        random_phase(60);
        calm = 0;
        random_phase(40);
        settle();

        // Alpha centres with a mid cutoff; stored residues keep their old centres.
        write_reg(hse_pkg::REG_ALPHA, hse_pkg::CutoffBits'(1));
        write_reg(hse_pkg::REG_CUTOFF, 42'd40000000);
        spread = 1500;
        random_phase(80);
        settle();

        write_reg(hse_pkg::REG_ALPHA, hse_pkg::CutoffBits'(0));
        write_reg(hse_pkg::REG_CUTOFF, 42'h3FFFFFFFFFF);
        full_range = 1;
        random_phase(70);
        settle();

        // Zero cutoff: only coincident centres touch.
        write_reg(hse_pkg::REG_CUTOFF, 42'd0);
        full_range = 0;
        spread = 2;
        random_phase(50);
        settle();

        // A long run of adds with every residue in range of every other.
        write_reg(hse_pkg::REG_CUTOFF, 42'h3FFFFFFFFFF);
        spread = 3000;
        it = '0;
        it.opcode = hse_pkg::OP_CLEAR;
        send(it);
        for (int i = 0; i < 170; i++) send(make_add());
        send(make_read(0));
        send(make_read(169));
        for (int i = 0; i < 10; i++) send(make_read($urandom_range(0, 1023)));
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("Sent %0d transactions over several cutoff and centre settings;",
                 items_sent);
        $display("checked %0d count reads, including a store of many mutual neighbours.",
                 reads_checked);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
